// ----- sv/gnms_pkg.sv -----
// gnms_pkg: shared types, constants and helper functions for the greedy nms engine
// no dependencies; imported by gnms_if, gnms_cell, gnms_iou and the top level
package gnms_pkg;

   localparam int MAX_BOXES_DEF = 128;
   localparam int KEEP_LIMIT    = 64;
   localparam int KEEP_AW       = $clog2(KEEP_LIMIT);
   localparam int KEEP_CW       = $clog2(KEEP_LIMIT + 1);

   localparam int COORD_W = 16;
   localparam int SCORE_W = 16;
   localparam int CLASS_W = 3;
   localparam int AREA_W  = 2 * COORD_W;
   localparam int THR_W   = 16;
   localparam int MK_W    = 7;
   localparam int CSR_DW  = 16;

   localparam logic [THR_W-1:0] IOU_THR_RST  = 16'd29491;
   localparam logic [MK_W-1:0]  MAX_KEEP_RST = 7'd40;

   // register indexes of the csr port
   localparam logic CSR_IOU_THR  = 1'b0;
   localparam logic CSR_MAX_KEEP = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [SCORE_W-1:0] score;
      logic [CLASS_W-1:0] cls;
   } box_type;

   // what the keep list remembers of an emitted box
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [AREA_W-1:0]  area;
   } kept_type;

   typedef struct packed {
      logic ins;
      logic pop;
      logic clr;
   } cell_ctl_type;

   // side length, zero when the far edge lies below the near edge
   function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
      return (hi > lo) ? (hi - lo) : '0;
   endfunction

   function automatic logic [AREA_W-1:0] box_area(input box_type b);
      logic [AREA_W-1:0] w;
      logic [AREA_W-1:0] h;
      w = AREA_W'(span(b.left, b.right));
      h = AREA_W'(span(b.top, b.bottom));
      return w * h;
   endfunction

endpackage

// ----- sv/gnms_if.sv -----
// gnms_if: valid/ready channel interfaces for candidate boxes and kept boxes
// depends on gnms_pkg for field widths
interface gnms_req_if import gnms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] box_left;
   logic [COORD_W-1:0] box_top;
   logic [COORD_W-1:0] box_right;
   logic [COORD_W-1:0] box_bottom;
   logic [SCORE_W-1:0] box_score;
   logic [CLASS_W-1:0] box_class;
   logic               frame_end;

   modport source (output valid, box_left, box_top, box_right, box_bottom, box_score,
                   box_class, frame_end, input ready);
   modport sink (input valid, box_left, box_top, box_right, box_bottom, box_score,
                 box_class, frame_end, output ready);
endinterface

interface gnms_rsp_if import gnms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] kept_left;
   logic [COORD_W-1:0] kept_top;
   logic [COORD_W-1:0] kept_right;
   logic [COORD_W-1:0] kept_bottom;
   logic [SCORE_W-1:0] kept_score;
   logic [CLASS_W-1:0] kept_class;
   logic               kept_last;
   logic               overflowed;

   modport source (output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                   kept_class, kept_last, overflowed, input ready);
   modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                 kept_class, kept_last, overflowed, output ready);
endinterface

// ----- sv/gnms_ram.sv -----
// gnms_ram: generic single-write, single-read ram with registered read data
// no dependencies
module gnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/gnms_cell.sv -----
// gnms_cell: one slot of the score-sorted candidate chain
// depends on gnms_pkg; instantiated in a row by the top level
module gnms_cell import gnms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  box_type      new_box,
   input  logic         prev_keep,
   input  box_type      prev_box,
   input  logic         prev_valid,
   input  box_type      next_box,
   input  logic         next_valid,
   output box_type      box,
   output logic         valid,
   output logic         keep
);
   box_type box_ff, box_in;
   logic    valid_ff, valid_in;

   // a cell holds its box when it scores at least the newcomer (ties keep arrival order)
   assign keep = valid_ff && (box_ff.score >= new_box.score);

   // clear, shift toward the head, or sorted insert
   always_comb begin
      box_in   = box_ff;
      valid_in = valid_ff;
      priority if (ctl.clr) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         box_in   = next_box;
         valid_in = next_valid;
      end else if (ctl.ins && !keep) begin
         if (prev_keep) begin
            box_in   = new_box;
            valid_in = 1'b1;
         end else begin
            box_in   = prev_box;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      box_ff <= box_in;
   end

   assign box   = box_ff;
   assign valid = valid_ff;
endmodule

// ----- sv/gnms_iou.sv -----
// gnms_iou: pipelined overlap test of one candidate against one kept box
// depends on gnms_pkg; fed from the keep list ram by the top level
module gnms_iou import gnms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  kept_type          kept,
   input  box_type           cand,
   input  logic [AREA_W-1:0] cand_area,
   input  logic [THR_W-1:0]  thr,
   output logic              out_valid,
   output logic              supp
);
   localparam int SUM_W  = AREA_W + 1;
   localparam int PROD_W = SUM_W + THR_W;

   logic [COORD_W-1:0] x1, y1, x2, y2;
   logic [AREA_W-1:0]  inter1_ff, inter1_in, inter2_ff, inter3_ff;
   logic [SUM_W-1:0]   sum1_ff, sum1_in, uni2_ff;
   logic [PROD_W-1:0]  prod3_ff;
   logic               v1_ff, v2_ff, v3_ff;

   // stage 1: intersection area and area sum
   always_comb begin
      x1 = (kept.left > cand.left) ? kept.left : cand.left;
      y1 = (kept.top > cand.top) ? kept.top : cand.top;
      x2 = (kept.right < cand.right) ? kept.right : cand.right;
      y2 = (kept.bottom < cand.bottom) ? kept.bottom : cand.bottom;
      inter1_in = AREA_W'(span(x1, x2)) * AREA_W'(span(y1, y2));
      sum1_in   = SUM_W'(kept.area) + SUM_W'(cand_area);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      inter1_ff <= inter1_in;
      sum1_ff   <= sum1_in;
      // stage 2: union
      inter2_ff <= inter1_ff;
      uni2_ff   <= sum1_ff - SUM_W'(inter1_ff);
      // stage 3: threshold times union
      inter3_ff <= inter2_ff;
      prod3_ff  <= PROD_W'(thr) * PROD_W'(uni2_ff);
   end

   // strict compare of inter scaled by 2^16 against the product
   assign supp      = ({1'b0, inter3_ff, 16'b0} > prod3_ff);
   assign out_valid = v3_ff;
endmodule

// ----- sv/greedy_nms_engine_unit.sv -----
// greedy_nms_engine_unit: top level of the greedy non-maximum suppression engine
// depends on gnms_pkg, gnms_if, gnms_ram, gnms_cell and gnms_iou
//
// Usage: candidate boxes enter on req_ch, one per transfer; frame_end marks the
// last one of a frame. Each candidate is placed in a chain of MAX_BOXES cells kept
// in descending score order, one candidate per cycle (req_ch.ready is high while
// loading). When the store is full the lowest score falls off and every result of
// that frame carries overflowed.
// After the closing candidate the chain shifts out toward its head one box at a
// time. Each box is tested against every box already kept, one test issued per
// cycle through the overlap pipeline; the compare is skipped while none is kept.
// Survivors leave on rsp_ch in score order, the last one of the frame with
// kept_last; the result stage holds one box, so a survivor is sent when its
// successor is known.
// While the receiver stalls, the scan waits with the pending box; no transfer is
// lost. Loading of the next frame starts once the last result is in the output
// register. Reset (synchronous) empties the store, the keep list and the output
// and restores the overlap threshold to 29491 and max_keep to 40. The csr port
// must be written only while the block is idle; the block does not enforce it.
module greedy_nms_engine_unit import gnms_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   gnms_req_if.sink          req_ch,
   gnms_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);
   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_HEAD   = 3'd1;
   localparam logic [2:0] ST_CMP    = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [THR_W-1:0]   thr_ff;
   logic [MK_W-1:0]    mk_ff;
   logic [KEEP_CW-1:0] keep_lim;
   logic               ovf_ff, ovf_in;
   box_type            cand_ff, cand_in;
   logic [AREA_W-1:0]  cand_area_ff, cand_area_in;
   box_type            pend_ff, pend_in;
   logic               have_pend_ff, have_pend_in;
   logic [KEEP_CW-1:0] nkept_ff, nkept_in;
   logic [KEEP_CW-1:0] iss_ff, iss_in;
   logic [KEEP_CW-1:0] res_ff, res_in;
   logic               supp_ff, supp_in;
   box_type            rsp_box_ff, rsp_box_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_xfer, slot_free, out_load, out_last;
   box_type            out_box;
   box_type            new_box;
   cell_ctl_type       ctl;
   logic               rd_en, wr_en;
   kept_type           wr_kept, rd_kept;
   logic               iou_v, iou_supp;

   box_type            box_a   [MAX_BOXES];
   logic               valid_a [MAX_BOXES];
   logic               keep_a  [MAX_BOXES];

   assign new_box.left   = req_ch.box_left;
   assign new_box.top    = req_ch.box_top;
   assign new_box.right  = req_ch.box_right;
   assign new_box.bottom = req_ch.box_bottom;
   assign new_box.score  = req_ch.box_score;
   assign new_box.cls    = req_ch.box_class;

   // chain of sorted cells
   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      if (i == 0) begin : g_head
         gnms_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .new_box(new_box),
            .prev_keep(1'b1), .prev_box(new_box), .prev_valid(1'b0),
            .next_box(box_a[i+1]), .next_valid(valid_a[i+1]),
            .box(box_a[i]), .valid(valid_a[i]), .keep(keep_a[i])
         );
      end else if (i == MAX_BOXES - 1) begin : g_tail
         gnms_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .new_box(new_box),
            .prev_keep(keep_a[i-1]), .prev_box(box_a[i-1]), .prev_valid(valid_a[i-1]),
            .next_box('0), .next_valid(1'b0),
            .box(box_a[i]), .valid(valid_a[i]), .keep(keep_a[i])
         );
      end else begin : g_mid
         gnms_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .new_box(new_box),
            .prev_keep(keep_a[i-1]), .prev_box(box_a[i-1]), .prev_valid(valid_a[i-1]),
            .next_box(box_a[i+1]), .next_valid(valid_a[i+1]),
            .box(box_a[i]), .valid(valid_a[i]), .keep(keep_a[i])
         );
      end
   end

   // keep list of boxes already emitted this frame
   assign wr_kept.left   = cand_ff.left;
   assign wr_kept.top    = cand_ff.top;
   assign wr_kept.right  = cand_ff.right;
   assign wr_kept.bottom = cand_ff.bottom;
   assign wr_kept.area   = cand_area_ff;

   gnms_ram #(.WIDTH($bits(kept_type)), .DEPTH(KEEP_LIMIT)) u_keep_ram (
      .clock(clock),
      .wr_en(wr_en), .wr_addr(nkept_ff[KEEP_AW-1:0]), .wr_data(wr_kept),
      .rd_en(rd_en), .rd_addr(iss_ff[KEEP_AW-1:0]), .rd_data(rd_kept)
   );

   logic rd_v_ff;

   gnms_iou u_iou (
      .clock(clock), .reset(reset), .in_valid(rd_v_ff), .kept(rd_kept),
      .cand(cand_ff), .cand_area(cand_area_ff), .thr(thr_ff),
      .out_valid(iou_v), .supp(iou_supp)
   );

   // clamp max_keep into 1..KEEP_LIMIT
   always_comb begin
      if (mk_ff == '0) begin
         keep_lim = KEEP_CW'(1);
      end else if (KEEP_CW'(mk_ff) > KEEP_CW'(KEEP_LIMIT)) begin
         keep_lim = KEEP_CW'(KEEP_LIMIT);
      end else begin
         keep_lim = KEEP_CW'(mk_ff);
      end
   end

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // load, scan and emit sequencing
   always_comb begin
      state_in     = state_ff;
      ovf_in       = ovf_ff;
      cand_in      = cand_ff;
      cand_area_in = cand_area_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      nkept_in     = nkept_ff;
      iss_in       = iss_ff;
      res_in       = res_ff;
      supp_in      = supp_ff;
      ctl          = '0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      out_load     = 1'b0;
      out_last     = 1'b0;
      out_box      = pend_ff;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_xfer) begin
               ctl.ins = 1'b1;
               if (valid_a[MAX_BOXES-1]) begin
                  ovf_in = 1'b1;
               end
               if (req_ch.frame_end) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (!valid_a[0]) begin
               state_in = ST_FLUSH;
            end else begin
               cand_in      = box_a[0];
               cand_area_in = box_area(box_a[0]);
               ctl.pop      = 1'b1;
               iss_in       = '0;
               res_in       = '0;
               supp_in      = 1'b0;
               state_in     = (nkept_ff == '0) ? ST_DECIDE : ST_CMP;
            end
         end
         ST_CMP: begin
            rd_en = (iss_ff < nkept_ff);
            if (rd_en) begin
               iss_in = iss_ff + KEEP_CW'(1);
            end
            if (iou_v) begin
               supp_in = supp_ff | iou_supp;
               res_in  = res_ff + KEEP_CW'(1);
               if (res_ff + KEEP_CW'(1) == nkept_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (supp_ff) begin
               state_in = ST_HEAD;
            end else if (!have_pend_ff || slot_free) begin
               out_load     = have_pend_ff;
               pend_in      = cand_ff;
               have_pend_in = 1'b1;
               wr_en        = 1'b1;
               nkept_in     = nkept_ff + KEEP_CW'(1);
               state_in     = (nkept_ff + KEEP_CW'(1) == keep_lim) ? ST_FLUSH : ST_HEAD;
            end
         end
         ST_FLUSH: begin
            if (!have_pend_ff || slot_free) begin
               out_load     = have_pend_ff;
               out_last     = 1'b1;
               have_pend_in = 1'b0;
               ctl.clr      = 1'b1;
               ovf_in       = 1'b0;
               nkept_in     = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_box_in   = rsp_box_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_box_in   = out_box;
         rsp_last_in  = out_last;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         thr_ff       <= IOU_THR_RST;
         mk_ff        <= MAX_KEEP_RST;
         ovf_ff       <= 1'b0;
         have_pend_ff <= 1'b0;
         nkept_ff     <= '0;
         iss_ff       <= '0;
         res_ff       <= '0;
         supp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         have_pend_ff <= have_pend_in;
         nkept_ff     <= nkept_in;
         iss_ff       <= iss_in;
         res_ff       <= res_in;
         supp_ff      <= supp_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_en;
         // csr writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_IOU_THR:  thr_ff <= csr_wdata[THR_W-1:0];
               CSR_MAX_KEEP: mk_ff  <= csr_wdata[MK_W-1:0];
               default: ;
            endcase
         end
      end
      cand_ff      <= cand_in;
      cand_area_ff <= cand_area_in;
      pend_ff      <= pend_in;
      rsp_box_ff   <= rsp_box_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kept_left   = rsp_box_ff.left;
   assign rsp_ch.kept_top    = rsp_box_ff.top;
   assign rsp_ch.kept_right  = rsp_box_ff.right;
   assign rsp_ch.kept_bottom = rsp_box_ff.bottom;
   assign rsp_ch.kept_score  = rsp_box_ff.score;
   assign rsp_ch.kept_class  = rsp_box_ff.cls;
   assign rsp_ch.kept_last   = rsp_last_ff;
   assign rsp_ch.overflowed  = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> slot_free)
      else $error("result register overwritten before transfer");

   a_keep_bound: assert property (@(posedge clock) disable iff (reset)
      nkept_ff <= keep_lim)
      else $error("keep count beyond limit");

   a_iou_in_cmp: assert property (@(posedge clock) disable iff (reset)
      iou_v |-> (state_ff == ST_CMP))
      else $error("overlap result outside compare phase");

   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      valid_a[1] |-> valid_a[0])
      else $error("chain head empty behind a filled cell");
`endif
endmodule
